### hdl/dbq_pkg.sv
`timescale 1ns / 1ps

package dbq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int CFG_W  = 5;
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int KIND_W = 3;
    localparam int WC_W   = 5;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GROUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROUP = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] MIN_GROUP_RST = 5'd1;
    localparam logic [CFG_W-1:0] MAX_GROUP_RST = 5'd4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUP      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MEMBER   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOGROUP  = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] member_key;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  member_out;
        logic [KEY_W-1:0]  group_number;
        logic              last_in_group;
        logic              last_of_run;
        logic [WC_W-1:0]   waiting_count;
        logic [KEY_W-1:0]  members_grouped_total;
    } t_out;

    // Effective group limits handed to the engine
    typedef struct packed {
        logic [CFG_W-1:0] emin;
        logic [CFG_W-1:0] emax;
    } t_cfg;

    // Result handed from the engine to the output register
    typedef struct packed {
        logic push;
        t_out res;
    } t_res_push;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_GROUP,
        S_EMIT,
        S_RESULT
    } t_state;

    // Logical queue position to physical memory address (ring from head)
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] sum;
        sum = {1'b0, lidx} + (CNT_W + 1)'(head);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### hdl/dbq_engine.sv
`timescale 1ns / 1ps

module dbq_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dbq_pkg::t_in       i_in_data,
    output logic               o_busy,
    input  dbq_pkg::t_cfg      i_cfg,
    input  logic               i_out_free,
    output dbq_pkg::t_res_push o_res
);

    // ID ring memory
    logic [dbq_pkg::KEY_W-1:0] mem [dbq_pkg::QUEUE_DEPTH];
    logic [dbq_pkg::KEY_W-1:0] r_rdata;

    dbq_pkg::t_state r_state, n_state;

    logic [dbq_pkg::IDX_W-1:0]  r_head, n_head;
    logic [dbq_pkg::CNT_W-1:0]  r_occ, n_occ;
    logic [dbq_pkg::KEY_W-1:0]  r_groups, n_groups;
    logic [dbq_pkg::KEY_W-1:0]  r_members, n_members;
    logic [dbq_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [dbq_pkg::KEY_W-1:0]  r_key, n_key;
    logic [dbq_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [dbq_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [dbq_pkg::CNT_W-1:0]  r_grp_left, n_grp_left;
    logic [dbq_pkg::KEY_W-1:0]  r_gnum, n_gnum;

    logic [dbq_pkg::IDX_W-1:0]  w_raddr;
    logic [dbq_pkg::IDX_W-1:0]  w_waddr;
    logic [dbq_pkg::KEY_W-1:0]  w_wdata;
    logic                       w_we;

    // Compare unit and group sizing
    logic                       w_found;
    logic                       w_at_end;
    logic                       w_grp_ok;
    logic                       w_shift_done;
    logic [dbq_pkg::CNT_W-1:0]  w_size;

    assign w_found      = (r_idx < r_occ) && (r_rdata == r_key);
    assign w_at_end     = (r_idx == r_occ);
    assign w_shift_done = ((r_idx + dbq_pkg::CNT_W'(1)) == r_occ);
    assign w_grp_ok     = (dbq_pkg::CMP_W'(r_occ) >= dbq_pkg::CMP_W'(i_cfg.emin))
                          && (r_occ != '0);
    assign w_size       = (dbq_pkg::CMP_W'(r_occ) < dbq_pkg::CMP_W'(i_cfg.emax))
                          ? r_occ : dbq_pkg::CNT_W'(i_cfg.emax);

    assign o_busy = (r_state != dbq_pkg::S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dbq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd == dbq_pkg::CMD_ADD ||
                        i_in_data.cmd == dbq_pkg::CMD_REMOVE) begin
                        n_state = dbq_pkg::S_SEARCH;
                    end else if (i_in_data.cmd == dbq_pkg::CMD_TICK) begin
                        n_state = w_grp_ok ? dbq_pkg::S_GROUP : dbq_pkg::S_RESULT;
                    end
                end
            end
            dbq_pkg::S_SEARCH: begin
                if (w_found) begin
                    n_state = (r_cmd == dbq_pkg::CMD_ADD) ? dbq_pkg::S_RESULT
                                                          : dbq_pkg::S_SHIFT;
                end else if (w_at_end) begin
                    n_state = dbq_pkg::S_RESULT;
                end
            end
            dbq_pkg::S_SHIFT: begin
                if (w_shift_done) begin
                    n_state = dbq_pkg::S_RESULT;
                end
            end
            dbq_pkg::S_GROUP: begin
                n_state = dbq_pkg::S_EMIT;
            end
            dbq_pkg::S_EMIT: begin
                if (i_out_free && r_grp_left == dbq_pkg::CNT_W'(1)) begin
                    n_state = w_grp_ok ? dbq_pkg::S_GROUP : dbq_pkg::S_IDLE;
                end
            end
            dbq_pkg::S_RESULT: begin
                if (i_out_free) begin
                    n_state = dbq_pkg::S_IDLE;
                end
            end
            default: n_state = dbq_pkg::S_IDLE;
        endcase
    end

    // Datapath control and result generation
    always_comb begin
        n_head     = r_head;
        n_occ      = r_occ;
        n_groups   = r_groups;
        n_members  = r_members;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_kind     = r_kind;
        n_idx      = r_idx;
        n_grp_left = r_grp_left;
        n_gnum     = r_gnum;
        w_raddr    = dbq_pkg::phys(r_head, '0);
        w_waddr    = dbq_pkg::phys(r_head, r_idx);
        w_wdata    = r_rdata;
        w_we       = 1'b0;
        o_res      = '0;

        unique case (r_state)
            dbq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in_data.cmd;
                    n_key = i_in_data.member_key;
                    n_idx = '0;
                    if (i_in_data.cmd == dbq_pkg::CMD_TICK) begin
                        n_key  = '0;
                        n_kind = dbq_pkg::KIND_NOGROUP;
                    end
                end
            end
            dbq_pkg::S_SEARCH: begin
                // Walk one entry a cycle; data for r_idx arrives now
                w_raddr = dbq_pkg::phys(r_head, r_idx + dbq_pkg::CNT_W'(1));
                if (w_found) begin
                    n_kind = dbq_pkg::KIND_DUP;
                end else if (w_at_end) begin
                    if (r_cmd == dbq_pkg::CMD_REMOVE) begin
                        n_kind = dbq_pkg::KIND_NOTFOUND;
                    end else if (r_occ == dbq_pkg::CNT_W'(dbq_pkg::QUEUE_DEPTH)) begin
                        n_kind = dbq_pkg::KIND_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = dbq_pkg::phys(r_head, r_occ);
                        w_wdata = r_key;
                        n_occ   = r_occ + dbq_pkg::CNT_W'(1);
                        n_kind  = dbq_pkg::KIND_ADDED;
                    end
                end else begin
                    n_idx = r_idx + dbq_pkg::CNT_W'(1);
                end
            end
            dbq_pkg::S_SHIFT: begin
                // Close the gap: entry idx+1 moves down to idx
                w_raddr = dbq_pkg::phys(r_head, r_idx + dbq_pkg::CNT_W'(2));
                if (w_shift_done) begin
                    n_occ  = r_occ - dbq_pkg::CNT_W'(1);
                    n_kind = dbq_pkg::KIND_REMOVED;
                end else begin
                    w_we  = 1'b1;
                    n_idx = r_idx + dbq_pkg::CNT_W'(1);
                end
            end
            dbq_pkg::S_GROUP: begin
                // Book the whole group up front; members follow
                n_gnum     = r_groups;
                n_groups   = r_groups + dbq_pkg::KEY_W'(1);
                n_members  = r_members + dbq_pkg::KEY_W'(w_size);
                n_occ      = r_occ - w_size;
                n_grp_left = w_size;
            end
            dbq_pkg::S_EMIT: begin
                if (i_out_free) begin
                    w_raddr                         = dbq_pkg::phys(r_head,
                                                          dbq_pkg::CNT_W'(1));
                    n_head                          = dbq_pkg::phys(r_head,
                                                          dbq_pkg::CNT_W'(1));
                    n_grp_left                      = r_grp_left - dbq_pkg::CNT_W'(1);
                    o_res.push                      = 1'b1;
                    o_res.res.kind                  = dbq_pkg::KIND_MEMBER;
                    o_res.res.member_out            = r_rdata;
                    o_res.res.group_number          = r_gnum;
                    o_res.res.last_in_group         = (r_grp_left == dbq_pkg::CNT_W'(1));
                    o_res.res.last_of_run           = (r_grp_left == dbq_pkg::CNT_W'(1))
                                                      && !w_grp_ok;
                    o_res.res.waiting_count         = dbq_pkg::WC_W'(r_occ);
                    o_res.res.members_grouped_total = r_members;
                end
            end
            dbq_pkg::S_RESULT: begin
                if (i_out_free) begin
                    o_res.push                      = 1'b1;
                    o_res.res.kind                  = r_kind;
                    o_res.res.member_out            = r_key;
                    o_res.res.group_number          = r_groups;
                    o_res.res.last_in_group         = 1'b0;
                    o_res.res.last_of_run           = 1'b1;
                    o_res.res.waiting_count         = dbq_pkg::WC_W'(r_occ);
                    o_res.res.members_grouped_total = r_members;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dbq_pkg::S_IDLE;
            r_head    <= '0;
            r_occ     <= '0;
            r_groups  <= '0;
            r_members <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_occ     <= n_occ;
            r_groups  <= n_groups;
            r_members <= n_members;
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_kind     <= n_kind;
        r_idx      <= n_idx;
        r_grp_left <= n_grp_left;
        r_gnum     <= n_gnum;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= dbq_pkg::CNT_W'(dbq_pkg::QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbq_pkg::S_SEARCH) |-> (r_idx <= r_occ))
        else $error("search index past occupancy");

    a_group_booked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbq_pkg::S_GROUP) |=>
            (r_groups == $past(r_groups) + dbq_pkg::KEY_W'(1)) &&
            (r_state == dbq_pkg::S_EMIT) && (r_occ < $past(r_occ)))
        else $error("group start did not book the group");

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbq_pkg::S_EMIT) |-> (r_grp_left != '0))
        else $error("emitting with no members left");

endmodule

### hdl/dedup_batching_queue_core.sv
`timescale 1ns / 1ps

// Ordered waiting queue of up to QUEUE_DEPTH 32-bit IDs with duplicate check,
// removal from any position and group formation on a tick. One transaction is
// worked at a time; stall stays high until its last result has been loaded
// into the output register. All work goes through the single read port of the
// ID ring memory, one entry per cycle while no result waits on the output
// register. An add walks the queue until a duplicate or the end and then
// appends if there is room; a remove searches and then shifts the tail
// down; a tick reports no group, or books each group and then emits its
// members. A result that meets a full output register waits until the
// register is free. Configuration writes must be made only while no
// transaction is in progress; the block itself does not enforce this.
module dedup_batching_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dbq_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dbq_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [dbq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dbq_pkg::CFG_W-1:0]         i_cfg_wdata
);

    logic [dbq_pkg::CFG_W-1:0] r_min_group;
    logic [dbq_pkg::CFG_W-1:0] r_max_group;
    logic                      r_out_valid;
    dbq_pkg::t_out             r_out;

    dbq_pkg::t_cfg             w_cfg;
    dbq_pkg::t_res_push        w_res;
    logic                      w_busy;
    logic                      w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_group <= dbq_pkg::MIN_GROUP_RST;
            r_max_group <= dbq_pkg::MAX_GROUP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dbq_pkg::CFG_MIN_GROUP: r_min_group <= i_cfg_wdata;
                dbq_pkg::CFG_MAX_GROUP: r_max_group <= i_cfg_wdata;
                default: r_min_group <= r_min_group;
            endcase
        end
    end

    // Effective limits: min at least 1, max at least min
    always_comb begin
        w_cfg.emin = (r_min_group == '0) ? dbq_pkg::CFG_W'(1) : r_min_group;
        w_cfg.emax = (r_max_group < w_cfg.emin) ? w_cfg.emin : r_max_group;
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    dbq_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_busy     (w_busy),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_res      (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.push) begin
            r_out <= w_res.res;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### verif/dedup_batching_queue_core_test.sv
`timescale 1ns / 1ps

module dedup_batching_queue_core_test;
    import dbq_pkg::*;

    // Code left unused by the block; such a transaction must be dropped silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_CYCLES    = 3 * QUEUE_DEPTH + 8;
    localparam int KEY_POOL_SIZE   = 24;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    // Mirror of the block state, kept in step with accepted transactions
    logic [KEY_W-1:0] queued_ids[$];
    logic [KEY_W-1:0] groups_done   = '0;
    logic [KEY_W-1:0] members_done  = '0;
    logic [CFG_W-1:0] min_group_cfg = MIN_GROUP_RST;
    logic [CFG_W-1:0] max_group_cfg = MAX_GROUP_RST;

    t_out expected_results[$];
    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   out_stall_pct  = 0;
    logic hold_off_req   = 1'b0;

    dedup_batching_queue_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Position of an ID in the waiting queue, -1 when absent
    function automatic int find_queued(input logic [KEY_W-1:0] key);
        foreach (queued_ids[i]) begin
            if (queued_ids[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Work out the results of one accepted transaction and update the mirror
    function automatic void predict_results(input t_in item);
        t_out             r;
        int               pos;
        int               emin;
        int               emax;
        int               take;
        int               occ_after;
        logic [KEY_W-1:0] gnum;
        r = '0;
        r.member_out = item.member_key;
        r.last_of_run = 1'b1;
        case (item.cmd)
            CMD_ADD: begin
                if (find_queued(item.member_key) >= 0) begin
                    r.kind = KIND_DUP;
                end else if (queued_ids.size() >= QUEUE_DEPTH) begin
                    r.kind = KIND_FULL;
                end else begin
                    queued_ids.insert(queued_ids.size(), item.member_key);
                    r.kind = KIND_ADDED;
                end
            end
            CMD_REMOVE: begin
                pos = find_queued(item.member_key);
                if (pos < 0) begin
                    r.kind = KIND_NOTFOUND;
                end else begin
                    queued_ids.delete(pos);
                    r.kind = KIND_REMOVED;
                end
            end
            CMD_TICK: begin
                emin = (min_group_cfg < 1) ? 1 : int'(min_group_cfg);
                emax = (max_group_cfg < emin) ? emin : int'(max_group_cfg);
                if (queued_ids.size() < emin) begin
                    r.kind = KIND_NOGROUP;
                    r.member_out = '0;
                end else begin
                    // one group per pass, oldest IDs first
                    while (queued_ids.size() >= emin) begin
                        take = (queued_ids.size() < emax) ? queued_ids.size() : emax;
                        gnum = groups_done;
                        groups_done = groups_done + 1;
                        members_done = members_done + KEY_W'(take);
                        occ_after = queued_ids.size() - take;
                        for (int i = 0; i < take; i++) begin
                            r.kind = KIND_MEMBER;
                            r.member_out = queued_ids[i];
                            r.group_number = gnum;
                            r.last_in_group = (i == take - 1);
                            r.last_of_run = (i == take - 1) && (occ_after < emin);
                            r.waiting_count = WC_W'(occ_after);
                            r.members_grouped_total = members_done;
                            expected_results.insert(expected_results.size(), r);
                        end
                        repeat (take) void'(queued_ids.pop_front());
                    end
                    return;
                end
            end
            default: begin
                return;
            end
        endcase
        r.group_number = groups_done;
        r.waiting_count = WC_W'(queued_ids.size());
        r.members_grouped_total = members_done;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void check_field(input string fname, input logic [KEY_W-1:0] exp_v,
                                        input logic [KEY_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out_data);
                mismatch_count++;
            end else begin
                check_field("kind", KEY_W'(expected_results[0].kind), KEY_W'(o_out_data.kind));
                check_field("member_out", expected_results[0].member_out,
                            o_out_data.member_out);
                check_field("group_number", expected_results[0].group_number,
                            o_out_data.group_number);
                check_field("last_in_group", KEY_W'(expected_results[0].last_in_group),
                            KEY_W'(o_out_data.last_in_group));
                check_field("last_of_run", KEY_W'(expected_results[0].last_of_run),
                            KEY_W'(o_out_data.last_of_run));
                check_field("waiting_count", KEY_W'(expected_results[0].waiting_count),
                            KEY_W'(o_out_data.waiting_count));
                check_field("members_grouped_total",
                            expected_results[0].members_grouped_total,
                            o_out_data.members_grouped_total);
                void'(expected_results.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Offer one transaction, with random idle cycles ahead, until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
        t_in item;
        item.cmd = cmd;
        item.member_key = key;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_results(item);
    endtask

    // Drop valid and let every expected result drain, then settle
    task automatic wait_until_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_GROUP) begin
            min_group_cfg = value;
        end else begin
            max_group_cfg = value;
        end
    endtask

    // Empty tick, key extremes, duplicate, absent remove, unused code
    task automatic test_single_ops();
        send_item(CMD_TICK, 32'h0000_0000);
        send_item(CMD_ADD, 32'h0000_0000);
        send_item(CMD_ADD, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'h0000_0000);
        send_item(CMD_REMOVE, 32'h5A5A_5A5A);
        send_item(CMD_REMOVE, 32'h0000_0000);
        send_item(CMD_UNUSED, 32'hA5A5_A5A5);
    endtask

    // Fill to depth, refuse a new ID, duplicate on full, then drain in groups
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            send_item(CMD_ADD, 32'h1357_9BDF ^ (i * 32'h0111_1111));
        end
        send_item(CMD_ADD, 32'h1234_5678);
        send_item(CMD_ADD, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 32'hFFFF_FFFF);
    endtask

    // Random mix under one group setting and one idling profile
    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                    input logic [CFG_W-1:0] min_v,
                                    input logic [CFG_W-1:0] max_v);
        logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
        int               pick;
        int               sent;
        wait_until_quiet();
        write_reg(CFG_MIN_GROUP, min_v);
        write_reg(CFG_MAX_GROUP, max_v);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom;
        end
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                            : $urandom;
            if (pick < 55) begin
                cmd = CMD_ADD;
            end else if (pick < 75) begin
                cmd = CMD_REMOVE;
                // mostly hit a waiting ID so removal shifts get exercised
                if (queued_ids.size() != 0 && $urandom_range(99) < 60) begin
                    key = queued_ids[$urandom_range(queued_ids.size() - 1)];
                end
            end else if (pick < 95) begin
                cmd = CMD_TICK;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, key);
            if (cmd != CMD_UNUSED) begin
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_input_backpressure();
        wait_until_quiet();
        write_reg(CFG_MIN_GROUP, 5'd1);
        write_reg(CFG_MAX_GROUP, 5'd4);
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_item(CMD_ADD, $urandom);
        end
        send_item(CMD_REMOVE, queued_ids[queued_ids.size() / 2]);
        send_item(CMD_TICK, $urandom);
        send_item(CMD_TICK, $urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_ops();
        test_full_queue();
        // group limits: below-one minimum, wide max, full-depth groups,
        // max under min, minimum beyond depth
        run_random_phase(48, 0, 0, 5'd0, 5'd0);
        run_random_phase(48, 59, 0, 5'd3, 5'd16);
        run_random_phase(48, 0, 59, 5'd16, 5'd16);
        run_random_phase(48, 33, 33, 5'd5, 5'd2);
        run_random_phase(48, 0, 0, 5'd31, 5'd31);
        test_input_backpressure();

        wait_until_quiet();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
